[sv/mnss_pkg.sv]
// ============================================================================
// mnss_pkg - shared definitions for the Markov next-state selector
// Field widths, default sizes and the action codes used by the core and
// its selector.
// ============================================================================
package mnss_pkg;

	// Default sizes of the chain.
	localparam int NUM_STATES_DEF  = 8;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int RANDOM_BITS_DEF = 16;

	// Fixed widths of the transaction fields.
	localparam int ROW_W    = 3;
	localparam int COLUMN_W = 3;
	localparam int WEIGHT_W = 16;
	localparam int FRAC_W   = 16;
	localparam int NEXT_W   = 3;

	// Action codes.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_DRAW  = 1'b1;

endpackage

[sv/markov_next_state_selector_core.sv]
// ============================================================================
// markov_next_state_selector_core - Markov chain step, roulette selection
// Holds a table of transition weights and a current state; write
// transactions set one weight, draw transactions pick and return the next
// state.
// ============================================================================
// The core accepts one transaction per clock cycle unless the input register
// is stalled, writes and draws mixed freely. A transaction is taken into an
// input register; when it retires a write updates the weight table and a draw
// reads the current state's row, forms the row sum, multiplies it by the
// random fraction and compares the cumulative weights against the resulting
// threshold, all combinationally, and loads the chosen state into the result
// register and into the current state, so a draw's result is offered once it
// retires, and a draw directly following another sees the updated state.
// The critical path is the row read, the row-sum adder, the
// sum-by-fraction multiplier and the cumulative compare chain. After reset
// every weight is one and the current state is zero. Writes whose row or
// column lie outside the table are dropped. A write produces no result
// transaction; a draw produces exactly one. Result back-pressure stalls the
// input register only when it holds a draw.
module markov_next_state_selector_core #(
	parameter int NUM_STATES  = mnss_pkg::NUM_STATES_DEF,
	parameter int WEIGHT_BITS = mnss_pkg::WEIGHT_BITS_DEF,
	parameter int RANDOM_BITS = mnss_pkg::RANDOM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          action,
	input  logic [mnss_pkg::ROW_W-1:0]    row,
	input  logic [mnss_pkg::COLUMN_W-1:0] column,
	input  logic [mnss_pkg::WEIGHT_W-1:0] weight,
	input  logic [mnss_pkg::FRAC_W-1:0]   random_fraction,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [mnss_pkg::NEXT_W-1:0]   next_state
);
	import mnss_pkg::*;

	localparam int STATE_W = $clog2(NUM_STATES);

	// Input register.
	logic                   valid_s1;
	logic                   action_s1;
	logic [ROW_W-1:0]       row_s1;
	logic [COLUMN_W-1:0]    column_s1;
	logic [WEIGHT_W-1:0]    weight_s1;
	logic [FRAC_W-1:0]      frac_s1;

	// Weight table, one packed row per source state, and the current state.
	logic [NUM_STATES-1:0][WEIGHT_BITS-1:0] weight_q [NUM_STATES];
	logic [STATE_W-1:0]                     cur_q;

	// Result register.
	logic              result_valid_q;
	logic [NEXT_W-1:0] next_state_q;

	logic                                   accept;
	logic                                   adv_s1;
	logic                                   draw_s1;
	logic                                   wr_in_range;
	logic [STATE_W-1:0]                     wr_row;
	logic [STATE_W-1:0]                     wr_col;
	logic [NUM_STATES-1:0][WEIGHT_BITS-1:0] cur_row;
	logic [STATE_W-1:0]                     pick;

	assign draw_s1 = (action_s1 == ACT_DRAW);

	// A write always retires; a draw retires once the result register is
	// free or is being emptied in this cycle.
	assign adv_s1     = valid_s1 && (!draw_s1 || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv_s1;
	assign accept     = item_valid && item_ready;

	assign wr_in_range = (int'(row_s1) < NUM_STATES) && (int'(column_s1) < NUM_STATES);
	assign wr_row      = STATE_W'(row_s1);
	assign wr_col      = STATE_W'(column_s1);

	assign cur_row = weight_q[cur_q];

	mnss_select #(
		.NUM_STATES  (NUM_STATES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.RANDOM_BITS (RANDOM_BITS)
	) u_select (
		.weights  (cur_row),
		.fraction (RANDOM_BITS'(frac_s1)),
		.column   (pick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// The payload is only looked at while valid_s1 is set.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			row_s1    <= row;
			column_s1 <= column;
			weight_s1 <= weight;
			frac_s1   <= random_fraction;
		end
	end

	// Every weight comes out of reset as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_STATES; r++) begin
				for (int c = 0; c < NUM_STATES; c++) begin
					weight_q[r][c] <= WEIGHT_BITS'(1);
				end
			end
		end else if (adv_s1 && !draw_s1 && wr_in_range) begin
			weight_q[wr_row][wr_col] <= WEIGHT_BITS'(weight_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (adv_s1 && draw_s1) begin
			cur_q <= pick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1 && draw_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && draw_s1) begin
			next_state_q <= NEXT_W'(pick);
		end
	end

	assign result_valid = result_valid_q;
	assign next_state   = next_state_q;

	// A retired draw shows up as the result and as the new current state.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && draw_s1 |=> result_valid_q && (next_state_q == NEXT_W'(cur_q)))
		else $error("draw result does not match the updated current state");

	// A stalled input register keeps its transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(action_s1) && $stable(frac_s1))
		else $error("stalled transaction lost from the input register");

	// A write never creates a result transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !draw_s1 && !result_valid_q |=> !result_valid_q)
		else $error("write produced a result transaction");

	// Only the fallback column may be picked with a zero weight.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && draw_s1 && (pick != STATE_W'(NUM_STATES - 1)) |->
			(cur_row[pick] != '0))
		else $error("zero-weight column selected");

endmodule

[sv/mnss_select.sv]
// ============================================================================
// mnss_select - roulette-wheel column selection for one row
// Sums the row, scales the sum by the random fraction and returns the first
// column whose cumulative weight exceeds the scaled threshold, else the last.
// ============================================================================
module mnss_select #(
	parameter int NUM_STATES  = mnss_pkg::NUM_STATES_DEF,
	parameter int WEIGHT_BITS = mnss_pkg::WEIGHT_BITS_DEF,
	parameter int RANDOM_BITS = mnss_pkg::RANDOM_BITS_DEF
) (
	input  logic [NUM_STATES-1:0][WEIGHT_BITS-1:0] weights,
	input  logic [RANDOM_BITS-1:0]                 fraction,
	output logic [$clog2(NUM_STATES)-1:0]          column
);
	import mnss_pkg::*;

	localparam int STATE_W = $clog2(NUM_STATES);
	localparam int SUM_W   = WEIGHT_BITS + $clog2(NUM_STATES);
	localparam int PROD_W  = SUM_W + RANDOM_BITS;

	logic [SUM_W-1:0]  row_sum;
	logic [PROD_W-1:0] product;
	logic [SUM_W-1:0]  threshold;
	logic [SUM_W-1:0]  running;
	logic              found;

	// Row total through a plain adder chain that synthesis balances.
	always_comb begin
		row_sum = '0;
		for (int c = 0; c < NUM_STATES; c++) begin
			row_sum = row_sum + SUM_W'(weights[c]);
		end
	end

	assign product   = PROD_W'(row_sum) * PROD_W'(fraction);
	assign threshold = product[PROD_W-1:RANDOM_BITS];

	// The first column whose running total passes the threshold wins; the
	// last column is the fallback when none does.
	always_comb begin
		running = '0;
		found   = 1'b0;
		column  = STATE_W'(NUM_STATES - 1);
		for (int c = 0; c < NUM_STATES; c++) begin
			running = running + SUM_W'(weights[c]);
			if (!found && (running > threshold)) begin
				found  = 1'b1;
				column = STATE_W'(c);
			end
		end
	end

endmodule
